>>> src/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared constants and control types for the systolic matrix multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

   // Array geometry and arithmetic widths
   localparam int ARRAY_SIZE  = 8;
   localparam int DRAIN_WAVES = 7;
   localparam int DATA_WIDTH  = 16;
   localparam int ACC_WIDTH   = 48;

   localparam int LANE_W  = $clog2(ARRAY_SIZE);
   localparam int PROD_W  = 2 * DATA_WIDTH;
   localparam int DRAIN_W = $clog2(DRAIN_WAVES + 1);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // write the request lane into the wave buffers
      logic wave;   // shift the cell array and start a multiply-accumulate
      logic emit;   // shift the sums out by one element, row-major
      logic clear;  // zero the operand cells at end of job
   } smm_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic mac_pending;  // a product or accumulation is still in flight
   } smm_status_type;

endpackage

`default_nettype wire

>>> src/smm_ctrl.sv
// ----------------------------------------------------------------------------
// smm_ctrl
// Job sequencer: takes request transfers, issues waves, runs the drain
// waves, waits for the MAC pipeline to settle and walks the result indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [smm_pkg::LANE_W-1:0]   req_lane,
   input  wire                          req_job_end,
   input  smm_pkg::smm_status_type      status,
   output smm_pkg::smm_cmd_type         cmd,
   output logic                         rsp_valid,
   output logic [smm_pkg::LANE_W-1:0]   rsp_row,
   output logic [smm_pkg::LANE_W-1:0]   rsp_column,
   output logic                         rsp_last
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam logic [smm_pkg::LANE_W-1:0]  LAST_LANE =
      smm_pkg::LANE_W'(smm_pkg::ARRAY_SIZE - 1);
   localparam logic [smm_pkg::DRAIN_W-1:0] LAST_DRAIN =
      smm_pkg::DRAIN_W'(smm_pkg::DRAIN_WAVES - 1);

   logic [1:0]                   state_ff, state_in;
   logic [smm_pkg::DRAIN_W-1:0]  drain_ff, drain_in;
   logic [smm_pkg::LANE_W-1:0]   row_ff, row_in;
   logic [smm_pkg::LANE_W-1:0]   col_ff, col_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [smm_pkg::LANE_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [smm_pkg::LANE_W-1:0]   rsp_col_ff, rsp_col_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         accept;
   logic                         emit_last;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign emit_last = (row_ff == LAST_LANE) && (col_ff == LAST_LANE);

   // Next state, commands and result indexes
   always_comb begin
      state_in     = state_ff;
      drain_in     = drain_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (req_lane == LAST_LANE) begin
                  cmd.wave = 1'b1;
                  if (req_job_end) begin
                     state_in = ST_DRAIN;
                     drain_in = '0;
                  end
               end
            end
         end
         ST_DRAIN: begin
            cmd.wave = 1'b1;
            if (drain_ff == LAST_DRAIN) begin
               state_in = ST_FLUSH;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!status.mac_pending) begin
               state_in = ST_EMIT;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_EMIT: begin
            cmd.emit     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_row_in   = row_ff;
            rsp_col_in   = col_ff;
            rsp_last_in  = emit_last;
            // advance row-major index
            if (col_ff == LAST_LANE) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (emit_last) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drain_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Result index registers
   always_ff @(posedge clock) begin
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_column = rsp_col_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

>>> src/smm_datapath.sv
// ----------------------------------------------------------------------------
// smm_datapath
// Wave buffers, operand cell array with one multiplier per cell, a product
// register stage and the per-cell accumulators, which shift out row-major.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_datapath (
   input  wire                                  clock,
   input  wire                                  reset,
   input  smm_pkg::smm_cmd_type                 cmd,
   output smm_pkg::smm_status_type              status,
   input  wire  [smm_pkg::LANE_W-1:0]           req_lane,
   input  wire  signed [smm_pkg::DATA_WIDTH-1:0] req_a_value,
   input  wire  signed [smm_pkg::DATA_WIDTH-1:0] req_b_value,
   output logic signed [smm_pkg::ACC_WIDTH-1:0]  rsp_value
);

   localparam int N  = smm_pkg::ARRAY_SIZE;
   localparam int DW = smm_pkg::DATA_WIDTH;
   localparam int AW = smm_pkg::ACC_WIDTH;
   localparam int PW = smm_pkg::PROD_W;

   logic signed [DW-1:0] a_buf_ff [N], a_buf_in [N];
   logic signed [DW-1:0] b_buf_ff [N], b_buf_in [N];
   logic signed [DW-1:0] a_feed [N];
   logic signed [DW-1:0] b_feed [N];
   logic signed [DW-1:0] a_cell_ff [N][N], a_cell_in [N][N];
   logic signed [DW-1:0] b_cell_ff [N][N], b_cell_in [N][N];
   logic signed [PW-1:0] prod_ff [N][N], prod_in [N][N];
   logic [AW-1:0]        acc_ff [N][N], acc_in [N][N];
   logic                 mul_en_ff;
   logic                 acc_en_ff;
   logic [AW-1:0]        value_ff;

   // Merge the incoming lane into the wave edge; update the buffers
   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (cmd.load && (req_lane == smm_pkg::LANE_W'(i))) begin
            a_feed[i] = req_a_value;
            b_feed[i] = req_b_value;
         end else begin
            a_feed[i] = a_buf_ff[i];
            b_feed[i] = b_buf_ff[i];
         end
         if (cmd.wave) begin
            a_buf_in[i] = '0;
            b_buf_in[i] = '0;
         end else begin
            a_buf_in[i] = a_feed[i];
            b_buf_in[i] = b_feed[i];
         end
      end
   end

   // Shift A right along rows and B down along columns on each wave
   always_comb begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            a_cell_in[i][j] = a_cell_ff[i][j];
            b_cell_in[i][j] = b_cell_ff[i][j];
            if (cmd.clear) begin
               a_cell_in[i][j] = '0;
               b_cell_in[i][j] = '0;
            end else if (cmd.wave) begin
               a_cell_in[i][j] = (j == 0) ? a_feed[i] : a_cell_ff[i][(j > 0) ? j - 1 : 0];
               b_cell_in[i][j] = (i == 0) ? b_feed[j] : b_cell_ff[(i > 0) ? i - 1 : 0][j];
            end
         end
      end
   end

   // One multiplier per cell, registered before the accumulate
   always_comb begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            prod_in[i][j] = PW'(a_cell_ff[i][j] * b_cell_ff[i][j]);
         end
      end
   end

   // Accumulate, or shift the sums out row-major with zero fill
   always_comb begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            acc_in[i][j] = acc_ff[i][j];
            if (cmd.emit) begin
               if (j < N - 1) begin
                  acc_in[i][j] = acc_ff[i][(j < N - 1) ? j + 1 : j];
               end else if (i < N - 1) begin
                  acc_in[i][j] = acc_ff[(i < N - 1) ? i + 1 : i][0];
               end else begin
                  acc_in[i][j] = '0;
               end
            end else if (acc_en_ff) begin
               acc_in[i][j] = acc_ff[i][j] + AW'(prod_ff[i][j]);
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_en_ff <= 1'b0;
         acc_en_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            a_buf_ff[i] <= '0;
            b_buf_ff[i] <= '0;
            for (int j = 0; j < N; j++) begin
               a_cell_ff[i][j] <= '0;
               b_cell_ff[i][j] <= '0;
               acc_ff[i][j]    <= '0;
            end
         end
      end else begin
         mul_en_ff <= cmd.wave;
         acc_en_ff <= mul_en_ff;
         for (int i = 0; i < N; i++) begin
            a_buf_ff[i] <= a_buf_in[i];
            b_buf_ff[i] <= b_buf_in[i];
            for (int j = 0; j < N; j++) begin
               a_cell_ff[i][j] <= a_cell_in[i][j];
               b_cell_ff[i][j] <= b_cell_in[i][j];
               acc_ff[i][j]    <= acc_in[i][j];
            end
         end
      end
   end

   // Product stage and result value
   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            prod_ff[i][j] <= prod_in[i][j];
         end
      end
      if (cmd.emit) begin
         value_ff <= acc_ff[0][0];
      end
   end

   assign status.mac_pending = mul_en_ff || acc_en_ff;
   assign rsp_value          = value_ff;

endmodule

`default_nettype wire

>>> src/systolic_matmul_8x8_unit.sv
// Non-closing lanes and ordinary closing lanes leave busy low.
// A job-end transfer starts DRAIN_WAVES drain waves (one a cycle), then a wait for
// the two-stage multiply/accumulate pipeline to settle; the 64 results then follow on
// consecutive cycles. busy drops with the last result. Synchronous reset clears
// the cell array, sums and wave buffers; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// systolic_matmul_8x8_unit
// Output-stationary 8x8 systolic multiply-accumulate array, Q8.8 operands,
// 48-bit Q32.16 sums emitted row-major at the end of each job.
// ----------------------------------------------------------------------------
`default_nettype none

module systolic_matmul_8x8_unit (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   output logic                                   busy,
   input  wire  [smm_pkg::LANE_W-1:0]             req_lane,
   input  wire  signed [smm_pkg::DATA_WIDTH-1:0]  req_a_value,
   input  wire  signed [smm_pkg::DATA_WIDTH-1:0]  req_b_value,
   input  wire                                    req_job_end,
   output logic                                   rsp_valid,
   output logic [smm_pkg::LANE_W-1:0]             rsp_row,
   output logic [smm_pkg::LANE_W-1:0]             rsp_column,
   output logic signed [smm_pkg::ACC_WIDTH-1:0]   rsp_value,
   output logic                                   rsp_last
);

   smm_pkg::smm_cmd_type    cmd;
   smm_pkg::smm_status_type status;

   // Sequencer
   smm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_lane    (req_lane),
      .req_job_end (req_job_end),
      .status      (status),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_row     (rsp_row),
      .rsp_column  (rsp_column),
      .rsp_last    (rsp_last)
   );

   // Cell array and accumulators
   smm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_lane    (req_lane),
      .req_a_value (req_a_value),
      .req_b_value (req_b_value),
      .rsp_value   (rsp_value)
   );

endmodule

`default_nettype wire
